// ===== hw/rtl/jsr_pkg.sv =====
// Shared types, constants and control structs for the JPEG scan restuffer.
package jsr_pkg;

	localparam int HOLD_DEPTH = 30;
	localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
	localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] BYTE_SOI  = 8'hD8;
	localparam logic [7:0] BYTE_EOI  = 8'hD9;
	localparam logic [7:0] BYTE_SOS  = 8'hDA;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SOI   = 3'd1;
	localparam logic [2:0] ST_BAD_MARK = 3'd2;
	localparam logic [2:0] ST_NO_SCAN  = 3'd3;
	localparam logic [2:0] ST_NO_EOI   = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef enum logic [2:0] {
		PH_SOI0, PH_SOI1, PH_MARK, PH_MCODE, PH_LENH, PH_LENL, PH_SKIP, PH_SCAN
	} phase_t;

	typedef enum logic [1:0] {
		PL_NONE, PL_HDR, PL_SCAN, PL_COMMIT
	} plan_t;

	typedef enum logic [2:0] {
		SEL_EMB, SEL_FF, SEL_ZERO, SEL_EOI, SEL_HOLD
	} sel_t;

	typedef enum logic [3:0] {
		CS_IDLE, CS_STEP, CS_EM_HDR, CS_EM_SCAN, CS_EM_ZERO,
		CS_C_FF, CS_C_FF0, CS_C_D9, CS_C_HOLD, CS_C_HOLD0,
		CS_ENDCHK, CS_E_FF, CS_E_D9, CS_FIN, CS_ERR
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
		sel_t sel;
		logic mark_last;
		logic idx_inc;
		logic end_check;
		logic push_err;
		logic clear;
	} jsr_cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  last;
		logic  err;
		logic  end_fail;
		logic  slot_free;
		logic  emb_ff;
		logic  hold_ff;
		logic  hold_done;
	} jsr_sts_t;

endpackage

// ===== hw/rtl/jsr_datapath.sv =====
// Datapath: parse state, hold store, output counter and output register.
module jsr_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  jsr_pkg::jsr_cmd_t cmd,
	output jsr_pkg::jsr_sts_t sts,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              cfg_write,
	input  logic [23:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic [2:0]        status
);
	import jsr_pkg::*;

	phase_t              phase_q, ph_n;
	logic [15:0]         skip_q, skip_n;
	logic [7:0]          lenh_q, lenh_n;
	logic [7:0]          mark_q, mark_n;
	logic [7:0]          prev_q, prev_n;
	logic                pv_q, pv_n;
	logic                fp_q, fp_n;
	logic                cand_q, cand_n;
	logic [HOLD_CW-1:0]  hc_q, hc_n;
	logic [2:0]          err_q, err_n;
	logic [23:0]         cap_q;
	logic [23:0]         cnt_q;
	logic [7:0]          x_q;
	logic                last_q;
	logic [7:0]          emb_q, emb_n;
	logic [HOLD_CW-1:0]  n_q, n_n;
	logic [HOLD_CW-1:0]  idx_q;
	logic [HOLD_CW-1:0]  idx_n;
	logic [7:0]          hold_mem [HOLD_DEPTH];
	logic                hwr;
	plan_t               plan;
	logic [15:0]         len;
	logic [15:0]         skip_m1;
	phase_t              seg_end;
	logic [2:0]          end_code;
	logic [7:0]          sel_byte;
	logic [7:0]          hold_rd_q;
	logic                slot_free;
	logic                do_emit;
	logic                ovf;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic [2:0]          status_q;

	assign len     = {lenh_q, x_q};
	assign skip_m1 = skip_q - 16'd1;
	assign seg_end = (mark_q == BYTE_SOS) ? PH_SCAN : PH_MARK;

	// Next commit index, so the registered hold read tracks idx_q
	assign idx_n = cmd.clear ? idx_q :
		cmd.step ? '0 :
		cmd.idx_inc ? idx_q + HOLD_CW'(1) : idx_q;

	// Work out the effect of the latched byte on the parse state
	always_comb begin
		ph_n   = phase_q;
		skip_n = skip_q;
		lenh_n = lenh_q;
		mark_n = mark_q;
		prev_n = prev_q;
		pv_n   = pv_q;
		fp_n   = fp_q;
		cand_n = cand_q;
		hc_n   = hc_q;
		err_n  = err_q;
		emb_n  = x_q;
		n_n    = '0;
		hwr    = 1'b0;
		plan   = PL_NONE;
		if (err_q == ST_OK) begin
			if (phase_q == PH_SCAN) begin
				if (!pv_q) begin
					prev_n = x_q;
					pv_n   = 1'b1;
				end else if (prev_q == BYTE_FF && x_q == BYTE_EOI) begin
					if (cand_q && hc_q != '0) begin
						plan = PL_COMMIT;
						n_n  = hc_q - HOLD_CW'(1);
						fp_n = 1'b0;
					end
					cand_n = 1'b1;
					hc_n   = '0;
					prev_n = BYTE_EOI;
				end else if (cand_q) begin
					if (!last_q) begin
						hwr    = 1'b1;
						prev_n = x_q;
						if (hc_q == HOLD_CW'(HOLD_DEPTH - 1)) begin
							plan   = PL_COMMIT;
							n_n    = HOLD_CW'(HOLD_DEPTH - 1);
							fp_n   = 1'b0;
							cand_n = 1'b0;
							hc_n   = '0;
						end else begin
							hc_n = hc_q + HOLD_CW'(1);
						end
					end
				end else begin
					plan   = PL_SCAN;
					emb_n  = prev_q;
					fp_n   = 1'b0;
					prev_n = x_q;
				end
			end else begin
				unique case (phase_q)
					PH_SOI0: begin
						if (x_q != BYTE_FF) err_n = ST_NO_SOI;
						else begin
							plan = PL_HDR;
							ph_n = PH_SOI1;
						end
					end
					PH_SOI1: begin
						if (x_q != BYTE_SOI) err_n = ST_NO_SOI;
						else begin
							plan = PL_HDR;
							ph_n = PH_MARK;
						end
					end
					PH_MARK: begin
						if (x_q != BYTE_FF) err_n = ST_BAD_MARK;
						else begin
							plan = PL_HDR;
							ph_n = PH_MCODE;
						end
					end
					PH_MCODE: begin
						plan = PL_HDR;
						if (x_q == BYTE_FF) ph_n = PH_MCODE;
						else if (x_q == BYTE_SOI || x_q == BYTE_EOI) ph_n = PH_MARK;
						else begin
							mark_n = x_q;
							ph_n   = PH_LENH;
						end
					end
					PH_LENH: begin
						plan   = PL_HDR;
						lenh_n = x_q;
						ph_n   = PH_LENL;
					end
					PH_LENL: begin
						if (len < 16'd2) err_n = ST_BAD_MARK;
						else begin
							plan   = PL_HDR;
							skip_n = len - 16'd2;
							ph_n   = (len == 16'd2) ? seg_end : PH_SKIP;
						end
					end
					default: begin
						plan   = PL_HDR;
						skip_n = skip_m1;
						if (skip_m1 == 16'd0) ph_n = seg_end;
					end
				endcase
			end
		end
	end

	// Check the block ending
	always_comb begin
		if (phase_q == PH_SOI0 || phase_q == PH_SOI1) end_code = ST_NO_SOI;
		else if (phase_q != PH_SCAN || !pv_q) end_code = ST_NO_SCAN;
		else if (!cand_q || fp_q) end_code = ST_NO_EOI;
		else end_code = ST_OK;
	end

	// Select the byte to emit
	always_comb begin
		case (cmd.sel)
			SEL_FF:   sel_byte = BYTE_FF;
			SEL_ZERO: sel_byte = BYTE_ZERO;
			SEL_EOI:  sel_byte = BYTE_EOI;
			SEL_HOLD: sel_byte = hold_rd_q;
			default:  sel_byte = emb_q;
		endcase
	end

	assign slot_free = !out_valid_q || out_ready;
	assign ovf       = cnt_q >= cap_q;
	assign do_emit   = cmd.emit && err_q == ST_OK && !ovf;

	// Parse state, counters and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOI0;
			skip_q  <= '0;
			lenh_q  <= '0;
			mark_q  <= '0;
			prev_q  <= '0;
			pv_q    <= 1'b0;
			fp_q    <= 1'b1;
			cand_q  <= 1'b0;
			hc_q    <= '0;
			err_q   <= ST_OK;
			cnt_q   <= '0;
			cap_q   <= 24'hFFFFFF;
			idx_q   <= '0;
			n_q     <= '0;
		end else begin
			if (cfg_write) cap_q <= cfg_data;
			if (cmd.clear) begin
				phase_q <= PH_SOI0;
				skip_q  <= '0;
				lenh_q  <= '0;
				mark_q  <= '0;
				prev_q  <= '0;
				pv_q    <= 1'b0;
				fp_q    <= 1'b1;
				cand_q  <= 1'b0;
				hc_q    <= '0;
				err_q   <= ST_OK;
				cnt_q   <= '0;
			end else if (cmd.step) begin
				phase_q <= ph_n;
				skip_q  <= skip_n;
				lenh_q  <= lenh_n;
				mark_q  <= mark_n;
				prev_q  <= prev_n;
				pv_q    <= pv_n;
				fp_q    <= fp_n;
				cand_q  <= cand_n;
				hc_q    <= hc_n;
				err_q   <= err_n;
				n_q     <= n_n;
				idx_q   <= '0;
			end else begin
				if (cmd.emit && err_q == ST_OK && ovf) err_q <= ST_OVERFLOW;
				if (do_emit) cnt_q <= cnt_q + 24'd1;
				if (cmd.end_check && err_q == ST_OK) err_q <= end_code;
				if (cmd.idx_inc) idx_q <= idx_q + HOLD_CW'(1);
			end
		end
	end

	// Latch the accepted transaction and the byte chosen by the step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= data_byte;
			last_q <= last_byte;
		end
		if (cmd.step) emb_q <= emb_n;
	end

	// Hold store: write on the step, read at the next commit index
	always_ff @(posedge clk) begin
		if (cmd.step && hwr) hold_mem[hc_q[HOLD_AW-1:0]] <= x_q;
		hold_rd_q <= hold_mem[idx_n[HOLD_AW-1:0]];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit || cmd.push_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_err) begin
			out_byte_q <= BYTE_ZERO;
			out_last_q <= 1'b1;
			status_q   <= err_q;
		end else if (do_emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= cmd.mark_last;
			status_q   <= ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign status    = status_q;

	assign sts.plan      = plan;
	assign sts.last      = last_q;
	assign sts.err       = err_q != ST_OK;
	assign sts.end_fail  = end_code != ST_OK;
	assign sts.slot_free = slot_free;
	assign sts.emb_ff    = emb_q == BYTE_FF;
	assign sts.hold_ff   = hold_rd_q == BYTE_FF;
	assign sts.hold_done = idx_q == n_q;

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q < HOLD_CW'(HOLD_DEPTH)) else $error("hold count out of range");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !cmd.clear) |=> err_q == $past(err_q))
		else $error("error code changed before block end");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(do_emit || cmd.push_err) |-> slot_free)
		else $error("output register overwritten");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= n_q) else $error("commit index past count");

endmodule

// ===== hw/rtl/jsr_ctrl.sv =====
// Controller: sequences the step and the output bytes of each transaction.
module jsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jsr_pkg::jsr_sts_t sts,
	output jsr_pkg::jsr_cmd_t cmd
);
	import jsr_pkg::*;

	ctl_state_t state_q, state_n;
	ctl_state_t post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CS_IDLE;
		else state_q <= state_n;
	end

	assign post = sts.last ? CS_ENDCHK : CS_IDLE;

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_EMB;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = CS_STEP;
				end
			end
			CS_STEP: begin
				cmd.step = 1'b1;
				unique case (sts.plan)
					PL_HDR:    state_n = CS_EM_HDR;
					PL_SCAN:   state_n = CS_EM_SCAN;
					PL_COMMIT: state_n = CS_C_FF;
					default:   state_n = post;
				endcase
			end
			CS_EM_HDR: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				state_n  = post;
			end
			CS_EM_SCAN: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				state_n  = sts.emb_ff ? CS_EM_ZERO : post;
			end
			CS_EM_ZERO: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_ZERO;
				state_n  = post;
			end
			CS_C_FF: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_FF;
				state_n  = CS_C_FF0;
			end
			CS_C_FF0: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_ZERO;
				state_n  = CS_C_D9;
			end
			CS_C_D9: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_EOI;
				state_n  = CS_C_HOLD;
			end
			CS_C_HOLD: begin
				if (sts.hold_done) state_n = post;
				else if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_HOLD;
					if (sts.hold_ff) state_n = CS_C_HOLD0;
					else cmd.idx_inc = 1'b1;
				end
			end
			CS_C_HOLD0: if (sts.slot_free) begin
				cmd.emit    = 1'b1;
				cmd.sel     = SEL_ZERO;
				cmd.idx_inc = 1'b1;
				state_n     = CS_C_HOLD;
			end
			CS_ENDCHK: begin
				cmd.end_check = 1'b1;
				state_n = (sts.err || sts.end_fail) ? CS_ERR : CS_E_FF;
			end
			CS_E_FF: if (sts.slot_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_FF;
				state_n  = CS_E_D9;
			end
			CS_E_D9: if (sts.slot_free) begin
				cmd.emit      = 1'b1;
				cmd.sel       = SEL_EOI;
				cmd.mark_last = 1'b1;
				state_n       = CS_FIN;
			end
			CS_FIN: begin
				if (sts.err) state_n = CS_ERR;
				else begin
					cmd.clear = 1'b1;
					state_n   = CS_IDLE;
				end
			end
			CS_ERR: if (sts.slot_free) begin
				cmd.push_err = 1'b1;
				cmd.clear    = 1'b1;
				state_n      = CS_IDLE;
			end
			default: state_n = CS_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/jpeg_scan_restuffer.sv =====
// Top level of the JPEG scan restuffer: controller plus datapath.
//
// Input channel (in_valid/in_ready, data_byte, last_byte) takes one byte of
// an unstuffed JPEG block per transaction, last_byte set on the final byte.
// Output channel (out_valid/out_ready, out_byte, out_last, status) gives the
// restuffed stream; out_last marks the final transaction of a block, which
// carries the closing D9 or, after an error, a status-only result.
// The config channel (cfg_valid/cfg_ready, cfg_data) sets the output byte
// budget; write it only between blocks.
// Sequence: a byte is accepted, then parsed, then each output byte it
// releases is emitted once the output register is free. A committed
// end-marker candidate gives FF 00 D9 and the held bytes, each FF with a
// 00 after it (at most 61 output bytes); the final byte adds FF D9 or status.
// Only one byte is in flight; the single output register is the limit.
// Reset clears all parse state and sets the budget to its maximum. While the
// receiver stalls the output register holds and the sequencer waits.
module jpeg_scan_restuffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);
	import jsr_pkg::*;

	jsr_cmd_t cmd;
	jsr_sts_t sts;

	assign cfg_ready = 1'b1;

	jsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jsr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.status    (status)
	);

endmodule
